FILE: rtl/utfb_pkg.sv
// Shared types and constants for the UART transmitter with byte queue.
// Used by every module of the block; depends on nothing else.
package utfb_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 8;
  localparam int DEFAULT_BREAK_LEN  = 10;
  localparam int DATA_BITS          = 8;
  localparam int QUEUED_W           = 4;

  // Item opcodes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Queue status seen by the controller.
  typedef struct packed {
    logic                 empty;
    logic                 full;
    logic [DATA_BITS-1:0] head;
  } q_status_t;

  // Queue requests from the controller.
  typedef struct packed {
    logic                 push;
    logic                 pop;
    logic [DATA_BITS-1:0] wdata;
  } q_ctrl_t;

endpackage

FILE: rtl/uart_tx_fifo_break.sv
// Top level of the bit-timed 8N1 UART transmitter with byte queue and break.
// Instantiates utfb_ctrl and utfb_queue; depends on utfb_pkg.
//
// Each input word is either one bit-time tick (opcode 0) or a byte write
// (opcode 1), and each produces exactly one result word carrying the serial
// line level, the idle flag, whether a write was taken, and the queue count
// (masked to four bits). The block takes one word per clock cycle for as long
// as results are taken: a word is first captured in an input register, and once
// the result register is free the sequencer, the queue and the result register
// update together from it, while the input register takes the next word.
// The queue is a FIFO_DEPTH-entry memory whose head word is read
// ahead into a register, so that the pop on the stop-bit tick never waits on
// the memory. A write to an idle transmitter starts the byte at once and
// does not use a queue slot; a write while busy is queued, or refused when the
// queue is full. A break request on any write is remembered and turns the next
// write that finds the transmitter idle into a break of BREAK_LEN ticks low,
// dropping that byte. There are no configuration registers.
module uart_tx_fifo_break #(
  parameter int FIFO_DEPTH = utfb_pkg::DEFAULT_FIFO_DEPTH,
  parameter int BREAK_LEN  = utfb_pkg::DEFAULT_BREAK_LEN
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic [utfb_pkg::DATA_BITS-1:0]  data_byte,
  input  logic                            break_request,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            tx_line,
  output logic                            idle,
  output logic                            accepted,
  output logic [utfb_pkg::QUEUED_W-1:0]   queued
);
  import utfb_pkg::*;

  // Input register.
  logic                 item_valid;
  logic                 op_q;
  logic [DATA_BITS-1:0] data_q;
  logic                 brk_q;

  // The captured word is processed when the result register is free or
  // is being emptied in this same cycle.
  logic advance;
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  q_ctrl_t              q_ctrl;
  q_status_t            q_status;
  logic                 empty_next;
  logic [QUEUED_W-1:0]  queued_next;
  logic                 line_next;
  logic                 done_next;
  logic                 accepted_next;

  utfb_ctrl #(
    .BREAK_LEN(BREAK_LEN)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .go            (advance),
    .opcode        (op_q),
    .data_byte     (data_q),
    .break_request (brk_q),
    .q_status      (q_status),
    .q_ctrl        (q_ctrl),
    .line_next     (line_next),
    .done_next     (done_next),
    .accepted_next (accepted_next)
  );

  utfb_queue #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (q_ctrl),
    .status      (q_status),
    .empty_next  (empty_next),
    .queued_next (queued_next)
  );

  // Input register: control bit reset, payload captured on acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      op_q   <= opcode;
      data_q <= data_byte;
      brk_q  <= break_request;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      tx_line  <= line_next;
      idle     <= done_next && empty_next;
      accepted <= accepted_next;
      queued   <= queued_next;
    end
  end

endmodule

FILE: rtl/utfb_queue.sv
// Byte queue: circular buffer memory with read and write pointers and a fill count.
// The head word is prefetched into a register so a pop never waits on the memory.
// Depends on utfb_pkg.
module utfb_queue #(
  parameter int FIFO_DEPTH = utfb_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  utfb_pkg::q_ctrl_t                 ctrl,
  output utfb_pkg::q_status_t               status,
  output logic                              empty_next,
  output logic [utfb_pkg::QUEUED_W-1:0]     queued_next
);
  import utfb_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int FW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

  logic [DATA_BITS-1:0] mem [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [FW-1:0] fill, fill_next;
  logic [DATA_BITS-1:0] head;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    fill_next   = fill;
    if (ctrl.push) begin
      wr_ptr_next = (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      fill_next   = fill + 1'b1;
    end
    if (ctrl.pop) begin
      rd_ptr_next = (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      fill_next   = fill - 1'b1;
    end
  end

  assign empty_next    = (fill_next == '0);
  assign queued_next   = QUEUED_W'(fill_next);
  assign status.empty  = (fill == '0);
  assign status.full   = (fill == FW'(FIFO_DEPTH));
  assign status.head   = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

  // Memory write port and registered read of the next head, with forwarding
  // of a word written into the slot that becomes the head.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= ctrl.wdata;
    end
    if (ctrl.push && (wr_ptr == rd_ptr_next)) begin
      head <= ctrl.wdata;
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

endmodule

FILE: rtl/utfb_ctrl.sv
// Transmit sequencer: phase machine, shift register, bit counter, line level
// and sticky break request. Depends on utfb_pkg.
module utfb_ctrl #(
  parameter int BREAK_LEN = utfb_pkg::DEFAULT_BREAK_LEN
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic                            opcode,
  input  logic [utfb_pkg::DATA_BITS-1:0]  data_byte,
  input  logic                            break_request,
  input  utfb_pkg::q_status_t             q_status,
  output utfb_pkg::q_ctrl_t               q_ctrl,
  output logic                            line_next,
  output logic                            done_next,
  output logic                            accepted_next
);
  import utfb_pkg::*;

  localparam int BW = $clog2(BREAK_LEN + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_BYTE,
    PH_STOP,
    PH_BREAK
  } phase_t;

  phase_t               phase, phase_next;
  logic [BW-1:0]        bit_index, bit_index_next;
  logic [DATA_BITS-1:0] shift_reg, shift_reg_next;
  logic                 line_level, line_level_next;
  logic                 break_pending, break_pending_next;
  logic                 bp;

  always_comb begin
    phase_next         = phase;
    bit_index_next     = bit_index;
    shift_reg_next     = shift_reg;
    line_level_next    = line_level;
    break_pending_next = break_pending;
    bp                 = break_pending | break_request;
    q_ctrl.push        = 1'b0;
    q_ctrl.pop         = 1'b0;
    q_ctrl.wdata       = data_byte;
    accepted_next      = 1'b0;
    if (go) begin
      if (opcode == OP_WRITE) begin
        break_pending_next = bp;
        if (phase == PH_IDLE) begin
          accepted_next   = 1'b1;
          line_level_next = 1'b0;
          bit_index_next  = '0;
          if (bp) begin
            phase_next         = PH_BREAK;
            break_pending_next = 1'b0;
          end else begin
            shift_reg_next = data_byte;
            phase_next     = PH_BYTE;
          end
        end else if (!q_status.full) begin
          q_ctrl.push   = 1'b1;
          accepted_next = 1'b1;
        end
      end else begin
        unique case (phase)
          PH_START: begin
            line_level_next = 1'b0;
            phase_next      = PH_BYTE;
            bit_index_next  = '0;
          end
          PH_BYTE: begin
            if (bit_index < BW'(DATA_BITS)) begin
              line_level_next = shift_reg[0];
              shift_reg_next  = shift_reg >> 1;
              bit_index_next  = bit_index + 1'b1;
            end else begin
              line_level_next = 1'b1;
              phase_next      = PH_STOP;
            end
          end
          PH_STOP: begin
            if (!q_status.empty) begin
              shift_reg_next = q_status.head;
              q_ctrl.pop     = 1'b1;
              phase_next     = PH_START;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_BREAK: begin
            if (bit_index < BW'(BREAK_LEN)) begin
              bit_index_next = bit_index + 1'b1;
            end else begin
              line_level_next = 1'b1;
              phase_next      = PH_STOP;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign line_next = line_level_next;
  assign done_next = (phase_next == PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_index     <= '0;
      shift_reg     <= '0;
      line_level    <= 1'b1;
      break_pending <= 1'b0;
    end else begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      shift_reg     <= shift_reg_next;
      line_level    <= line_level_next;
      break_pending <= break_pending_next;
    end
  end

endmodule

FILE: rtl/utfb_checker.sv
// Port-level checker for uart_tx_fifo_break, attached by the bind below.
// Depends on utfb_pkg for field widths.
module utfb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            opcode,
  input logic [utfb_pkg::DATA_BITS-1:0]  data_byte,
  input logic                            break_request,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            tx_line,
  input logic                            idle,
  input logic                            accepted,
  input logic [utfb_pkg::QUEUED_W-1:0]   queued
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({tx_line, idle, accepted, queued}))
    else $error("result changed while stalled");

  // An idle transmitter leaves the line high with nothing queued.
  a_idle_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> tx_line && (queued == '0))
    else $error("idle result with line low or bytes queued");

  // No result is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A waiting input word is not withdrawn.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input word withdrawn before acceptance");

endmodule

bind uart_tx_fifo_break utfb_checker u_utfb_checker (.*);
